/* rtl/bat_pkg.sv */
// bat_pkg: shared types, constants and the blob sprite table for the autotile lookup.
// No dependencies; every other file but bat_stream_if imports it.
package bat_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ROWS          = 64;
  localparam int DEF_MAX_COLS          = 64;
  localparam int DEF_SHEET_TILE_PIXELS = 32;

  // Sprite sheet is always eight columns wide
  localparam int SHEET_COLUMNS = 8;

  localparam int       LONELY_SPRITE = 47;
  localparam int       QUEUE_DEPTH   = 2;
  localparam int       NUM_TAPS      = 9;
  localparam int       DIM_W         = 7;
  localparam logic [DIM_W-1:0] MAP_DIM_RESET = 7'd64;

  // Input func codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic {
    CFG_MAP_ROWS = 1'b0,
    CFG_MAP_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TT_GROUND = 2'd0,
    TT_WATER  = 2'd1,
    TT_MUD    = 2'd2,
    TT_MARKER = 2'd3
  } terrain_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_OOR   = 2'd2
  } cmd_op_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_WRITE = 3'd1,
    BK_READ  = 3'd2,
    BK_DRAIN = 3'd3,
    BK_DONE  = 3'd4
  } back_state_t;

  // Neighbor taps, in read order
  localparam logic [3:0] TAP_C  = 4'd0;
  localparam logic [3:0] TAP_N  = 4'd1;
  localparam logic [3:0] TAP_NE = 4'd2;
  localparam logic [3:0] TAP_E  = 4'd3;
  localparam logic [3:0] TAP_SE = 4'd4;
  localparam logic [3:0] TAP_S  = 4'd5;
  localparam logic [3:0] TAP_SW = 4'd6;
  localparam logic [3:0] TAP_W  = 4'd7;
  localparam logic [3:0] TAP_NW = 4'd8;

  typedef struct packed {
    logic       func;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] tile_type;
  } in_beat_t;

  typedef struct packed {
    logic       out_of_range;
    logic       draw_water;
    logic       draw_ground;
    logic [5:0] ground_sprite;
    logic [7:0] ground_sheet_x;
    logic [7:0] ground_sheet_y;
    logic       draw_mud;
    logic [5:0] mud_sprite;
    logic [7:0] mud_sheet_x;
    logic [7:0] mud_sheet_y;
  } out_beat_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_op_t    op;
    logic [5:0] row;
    logic [5:0] col;
    terrain_t   code;
  } cmd_t;

  // Map size actually in use
  typedef struct packed {
    logic [DIM_W-1:0] rows_used;
    logic [DIM_W-1:0] cols_used;
  } bounds_t;

  function automatic logic signed [7:0] tap_drow(input logic [3:0] tap);
    logic signed [7:0] d;
    case (tap)
      TAP_N, TAP_NE, TAP_NW: d = -8'sd1;
      TAP_SE, TAP_S, TAP_SW: d = 8'sd1;
      default:               d = 8'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [7:0] tap_dcol(input logic [3:0] tap);
    logic signed [7:0] d;
    case (tap)
      TAP_NE, TAP_E, TAP_SE: d = 8'sd1;
      TAP_SW, TAP_W, TAP_NW: d = -8'sd1;
      default:               d = 8'sd0;
    endcase
    return d;
  endfunction

  // 47-tile blob table; masks the diagonal rule rules out give sprite 0
  function automatic logic [5:0] blob_sprite(input logic [7:0] mask);
    logic [5:0] s;
    case (mask)
      8'd1:   s = 6'd1;
      8'd5:   s = 6'd2;
      8'd7:   s = 6'd3;
      8'd17:  s = 6'd4;
      8'd21:  s = 6'd5;
      8'd23:  s = 6'd6;
      8'd29:  s = 6'd7;
      8'd31:  s = 6'd8;
      8'd85:  s = 6'd9;
      8'd87:  s = 6'd10;
      8'd95:  s = 6'd11;
      8'd119: s = 6'd12;
      8'd127: s = 6'd13;
      8'd4:   s = 6'd14;
      8'd16:  s = 6'd15;
      8'd64:  s = 6'd16;
      8'd20:  s = 6'd17;
      8'd80:  s = 6'd18;
      8'd65:  s = 6'd19;
      8'd28:  s = 6'd20;
      8'd112: s = 6'd21;
      8'd193: s = 6'd22;
      8'd68:  s = 6'd23;
      8'd84:  s = 6'd24;
      8'd81:  s = 6'd25;
      8'd69:  s = 6'd26;
      8'd92:  s = 6'd27;
      8'd113: s = 6'd28;
      8'd197: s = 6'd29;
      8'd116: s = 6'd30;
      8'd209: s = 6'd31;
      8'd71:  s = 6'd32;
      8'd124: s = 6'd33;
      8'd241: s = 6'd34;
      8'd199: s = 6'd35;
      8'd93:  s = 6'd36;
      8'd117: s = 6'd37;
      8'd213: s = 6'd38;
      8'd125: s = 6'd39;
      8'd245: s = 6'd40;
      8'd215: s = 6'd41;
      8'd221: s = 6'd42;
      8'd253: s = 6'd43;
      8'd247: s = 6'd44;
      8'd223: s = 6'd45;
      8'd255: s = 6'd46;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/bat_stream_if.sv */
// bat_stream_if: valid/ready channel carrying one payload per beat.
// Payload type is a parameter; no package dependency.
interface bat_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bat_fifo.sv */
// bat_fifo: short command queue between front and back.
// Depends on bat_pkg (cmd_t, QUEUE_DEPTH).
module bat_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bat_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bat_pkg::cmd_t  pop_data
);
  import bat_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/bat_front.sv */
// bat_front: accepts input beats, bounds-checks and classifies them into commands.
// Depends on bat_pkg and bat_stream_if.
module bat_front (
  bat_stream_if.sink       in_ch,
  input  bat_pkg::bounds_t bounds,
  input  logic             q_full,
  output logic             push,
  output bat_pkg::cmd_t    push_data
);
  import bat_pkg::*;

  in_beat_t beat;
  logic     oor;

  assign beat        = in_ch.payload;
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign oor = ({1'b0, beat.row} >= bounds.rows_used) ||
               ({1'b0, beat.col} >= bounds.cols_used);

  always_comb begin
    push_data.row = beat.row;
    push_data.col = beat.col;
    // codes above mud collapse to marker
    if (beat.tile_type > 8'd2) begin
      push_data.code = TT_MARKER;
    end else begin
      push_data.code = terrain_t'(beat.tile_type[1:0]);
    end
    if (oor) begin
      push_data.op = CMD_OOR;
    end else if (beat.func == FUNC_QUERY) begin
      push_data.op = CMD_QUERY;
    end else begin
      push_data.op = CMD_WRITE;
    end
  end

endmodule

/* rtl/bat_back.sv */
// bat_back: terrain store, neighbor read sequencer, blob mask and result register.
// Depends on bat_pkg and bat_stream_if.
module bat_back #(
  parameter int MAX_ROWS          = bat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS          = bat_pkg::DEF_MAX_COLS,
  parameter int SHEET_TILE_PIXELS = bat_pkg::DEF_SHEET_TILE_PIXELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bat_pkg::bounds_t bounds,
  input  logic             q_valid,
  input  bat_pkg::cmd_t    q_data,
  output logic             q_pop,
  bat_stream_if.source     out_ch
);
  import bat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SX_W  = $clog2(SHEET_COLUMNS * SHEET_TILE_PIXELS + 1);

  back_state_t state_r, state_nxt;

  cmd_t          cmd_r;
  logic [3:0]    step_r;
  logic          pend_act_r;
  logic          pend_vld_r;
  logic [3:0]    pend_tap_r;
  terrain_t      rdata_r;
  terrain_t      ctr_r;
  logic [NUM_TAPS-1:0] gm_r;
  logic [NUM_TAPS-1:0] mm_r;
  logic          out_vld_r;
  out_beat_t     out_data_r;

  terrain_t      store_mem [DEPTH];

  logic signed [7:0] nr, nc;
  logic              tap_in_map;
  logic [AW-1:0]     addr;
  logic              mem_we, mem_re, load_out;
  out_beat_t         res;

  // Neighbor address for the current tap
  assign nr = signed'({2'b00, cmd_r.row}) + tap_drow(step_r);
  assign nc = signed'({2'b00, cmd_r.col}) + tap_dcol(step_r);
  assign tap_in_map = !nr[7] && !nc[7] &&
                      (nr[6:0] < bounds.rows_used) && (nc[6:0] < bounds.cols_used);
  assign addr = AW'(AW'(nr[6:0]) * AW'(MAX_COLS)) + AW'(nc[6:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            CMD_WRITE: state_nxt = BK_WRITE;
            CMD_QUERY: state_nxt = BK_READ;
            default:   state_nxt = BK_DONE;
          endcase
        end
      end
      BK_WRITE: state_nxt = BK_DONE;
      BK_READ: begin
        if (step_r == 4'(NUM_TAPS - 1)) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: state_nxt = BK_DONE;
      BK_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == BK_IDLE) && q_valid;
    mem_we   = (state_r == BK_WRITE);
    mem_re   = (state_r == BK_READ) && tap_in_map;
    load_out = (state_r == BK_DONE) && (!out_vld_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      pend_act_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_act_r <= (state_r == BK_READ);
      pend_vld_r <= mem_re;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Single-port store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[addr] <= cmd_r.code;
    end
    if (mem_re) begin
      rdata_r <= store_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_data;
      step_r <= '0;
    end else if (state_r == BK_READ) begin
      step_r <= step_r + 1'b1;
    end
    pend_tap_r <= step_r;
    // off-map neighbors match both layers
    if (pend_act_r) begin
      gm_r[pend_tap_r] <= !pend_vld_r || (rdata_r != TT_WATER);
      mm_r[pend_tap_r] <= !pend_vld_r || (rdata_r == TT_MUD);
      if (pend_vld_r && (pend_tap_r == TAP_C)) begin
        ctr_r <= rdata_r;
      end
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  function automatic logic [7:0] blob_mask(input logic [NUM_TAPS-1:0] m);
    logic n, e, s, w;
    n = m[TAP_N];
    e = m[TAP_E];
    s = m[TAP_S];
    w = m[TAP_W];
    return {n & w & m[TAP_NW], w, s & w & m[TAP_SW], s,
            s & e & m[TAP_SE], e, n & e & m[TAP_NE], n};
  endfunction

  function automatic logic [7:0] sheet_x(input logic [5:0] sp);
    return 8'(SX_W'(sp % 6'(SHEET_COLUMNS)) * SX_W'(SHEET_TILE_PIXELS));
  endfunction

  function automatic logic [7:0] sheet_y(input logic [5:0] sp);
    return 8'(SX_W'(sp / 6'(SHEET_COLUMNS)) * SX_W'(SHEET_TILE_PIXELS));
  endfunction

  logic [7:0] g_mask, m_mask;
  logic [5:0] g_sp, m_sp;

  always_comb begin
    g_mask = blob_mask(gm_r);
    m_mask = blob_mask(mm_r);
    // isolated plain ground gets the lonely sprite
    g_sp   = ((g_mask == 8'd0) && (ctr_r == TT_GROUND)) ? 6'(LONELY_SPRITE)
                                                       : blob_sprite(g_mask);
    m_sp   = blob_sprite(m_mask);
    res    = '0;
    case (cmd_r.op)
      CMD_OOR: res.out_of_range = 1'b1;
      CMD_QUERY: begin
        if (ctr_r == TT_WATER) begin
          res.draw_water = 1'b1;
        end else begin
          res.draw_ground    = 1'b1;
          res.ground_sprite  = g_sp;
          res.ground_sheet_x = sheet_x(g_sp);
          res.ground_sheet_y = sheet_y(g_sp);
          if (ctr_r == TT_MUD) begin
            res.draw_mud    = 1'b1;
            res.mud_sprite  = m_sp;
            res.mud_sheet_x = sheet_x(m_sp);
            res.mud_sheet_y = sheet_y(m_sp);
          end
        end
      end
      default: res = '0;
    endcase
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_data_r;

endmodule

/* rtl/blob_autotile_lookup.sv */
// blob_autotile_lookup: top level of the blob autotile lookup block.
// Depends on bat_pkg, bat_stream_if, bat_front, bat_fifo and bat_back.
//
// Tile map with 47-tile blob autotiling. Each in_ch beat either writes a
// cell's terrain (func 0: ground, water, mud, anything above mud is a marker
// that behaves as ground) or queries the sprites for a cell (func 1). Every
// beat yields exactly one out_ch beat, in order. Cells outside map_rows x
// map_cols (clamped to MAX_ROWS x MAX_COLS) are flagged out_of_range and
// ignored. The front classifies and bounds-checks beats into a two-entry
// command queue, so input keeps flowing, until the queue fills, while the
// back end works and while a result waits in the output register. The back
// end owns a single-port terrain store: a query reads the center and its
// eight neighbors one per cycle, going through dispatch, the nine reads, a
// drain and the result; a write through dispatch, the write and the result,
// and an out-of-range beat through dispatch and the result. The store port
// sets that rate. Reading a cell that was never written gives undefined
// sprites; the store is not cleared at reset. Configuration writes (cfg_idx
// 0 rows, 1 columns) take effect at once and belong to idle periods only.
module blob_autotile_lookup #(
  parameter int MAX_ROWS          = bat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS          = bat_pkg::DEF_MAX_COLS,
  parameter int SHEET_TILE_PIXELS = bat_pkg::DEF_SHEET_TILE_PIXELS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bat_stream_if.sink                in_ch,
  bat_stream_if.source              out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [bat_pkg::DIM_W-1:0] cfg_wdata
);
  import bat_pkg::*;

  logic [DIM_W-1:0] map_rows_r;
  logic [DIM_W-1:0] map_cols_r;
  bounds_t          bounds;

  logic push, q_full, q_pop, q_valid;
  cmd_t push_data, q_data;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r <= MAP_DIM_RESET;
      map_cols_r <= MAP_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAP_ROWS: map_rows_r <= cfg_wdata;
        CFG_MAP_COLS: map_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the configured size to the store
  assign bounds.rows_used = (int'(map_rows_r) < MAX_ROWS) ? map_rows_r : DIM_W'(MAX_ROWS);
  assign bounds.cols_used = (int'(map_cols_r) < MAX_COLS) ? map_cols_r : DIM_W'(MAX_COLS);

  bat_front u_front (
    .in_ch     (in_ch),
    .bounds    (bounds),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bat_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  bat_back #(
    .MAX_ROWS          (MAX_ROWS),
    .MAX_COLS          (MAX_COLS),
    .SHEET_TILE_PIXELS (SHEET_TILE_PIXELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .bounds  (bounds),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
